[rtl/core/tpbb_pkg.sv]
// ----------------------------------------------------------------------------
// tpbb_pkg: shared types and constants for the transformed-point bounding box
// Coordinate types, register indexes, reset values and the lane extractor.
// ----------------------------------------------------------------------------
package tpbb_pkg;

    localparam int COORD_W = 16;
    localparam int ROW_W   = 64;
    localparam int Q_FRAC  = 14;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int ACC_W   = 34;
    localparam int RND_W   = ACC_W - Q_FRAC;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef t_coord [2:0]              t_vec;
    typedef logic [ROW_W-1:0]          t_row;
    typedef logic [1:0]                t_cfg_idx;

    // Configuration register indexes
    localparam t_cfg_idx CFG_ROW_X = 2'd0;
    localparam t_cfg_idx CFG_ROW_Y = 2'd1;
    localparam t_cfg_idx CFG_ROW_Z = 2'd2;

    // Identity transform after reset
    localparam t_row ROW_X_RST = 64'h0000_0000_0000_4000;
    localparam t_row ROW_Y_RST = 64'h0000_0000_4000_0000;
    localparam t_row ROW_Z_RST = 64'h0000_4000_0000_0000;

    // Load strobes for the two arithmetic stages
    typedef struct packed {
        logic ld_mul;
        logic ld_sum;
    } t_pipe_ctl;

    // Lane k of a row register: bits 16k..16k+15
    function automatic t_coord lane(input t_row row, input logic [1:0] k);
        return t_coord'(row[COORD_W*k +: COORD_W]);
    endfunction

endpackage

[rtl/core/tpbb_row.sv]
// ----------------------------------------------------------------------------
// tpbb_row: one row of the affine transform
// Registers three coefficient products, then sums, rounds and saturates.
// ----------------------------------------------------------------------------
module tpbb_row (
    input  logic                i_clk,
    input  tpbb_pkg::t_pipe_ctl i_ctl,
    input  tpbb_pkg::t_row      i_row,
    input  tpbb_pkg::t_vec      i_pt,
    output tpbb_pkg::t_coord    o_coord
);

    logic signed [tpbb_pkg::PROD_W-1:0] r_prod [3];
    tpbb_pkg::t_coord                   r_tr;
    tpbb_pkg::t_coord                   r_coord;

    logic signed [tpbb_pkg::ACC_W-1:0]  acc;
    logic signed [tpbb_pkg::ACC_W-1:0]  acc_rnd;
    logic signed [tpbb_pkg::RND_W-1:0]  rnd;
    tpbb_pkg::t_coord                   n_coord;

    // Product stage
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_mul) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= $signed(tpbb_pkg::lane(i_row, 2'(k))) * $signed(i_pt[k]);
            end
            r_tr <= tpbb_pkg::lane(i_row, 2'd3);
        end
    end

    // Sum, round half up, saturate
    always_comb begin
        acc = tpbb_pkg::ACC_W'(r_prod[0]) + tpbb_pkg::ACC_W'(r_prod[1])
            + tpbb_pkg::ACC_W'(r_prod[2])
            + $signed({{(tpbb_pkg::ACC_W - tpbb_pkg::COORD_W - tpbb_pkg::Q_FRAC){r_tr[15]}},
                       r_tr, {tpbb_pkg::Q_FRAC{1'b0}}});
        acc_rnd = acc + $signed(tpbb_pkg::ACC_W'(1) <<< (tpbb_pkg::Q_FRAC - 1));
        rnd     = acc_rnd[tpbb_pkg::ACC_W-1:tpbb_pkg::Q_FRAC];
        if (rnd[tpbb_pkg::RND_W-1:tpbb_pkg::COORD_W-1] == '0
            || rnd[tpbb_pkg::RND_W-1:tpbb_pkg::COORD_W-1] == '1) begin
            n_coord = rnd[tpbb_pkg::COORD_W-1:0];
        end else if (rnd[tpbb_pkg::RND_W-1]) begin
            n_coord = 16'sh8000;
        end else begin
            n_coord = 16'sh7FFF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_sum) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

[rtl/core/tpbb_box.sv]
// ----------------------------------------------------------------------------
// tpbb_box: running axis-aligned box
// Holds both corners and the empty flag; grows the box by one point a cycle while i_load is high.
// ----------------------------------------------------------------------------
module tpbb_box (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_restart,
    input  tpbb_pkg::t_vec i_pt,
    output tpbb_pkg::t_vec o_lo,
    output tpbb_pkg::t_vec o_hi
);

    tpbb_pkg::t_vec r_lo;
    tpbb_pkg::t_vec r_hi;
    logic           r_empty;
    tpbb_pkg::t_vec n_lo;
    tpbb_pkg::t_vec n_hi;

    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        for (int k = 0; k < 3; k++) begin
            if (i_restart || r_empty) begin
                n_lo[k] = i_pt[k];
                n_hi[k] = i_pt[k];
            end else if ($signed(i_pt[k]) < $signed(r_lo[k])) begin
                n_lo[k] = i_pt[k];
            end else if ($signed(i_pt[k]) > $signed(r_hi[k])) begin
                n_hi[k] = i_pt[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= '0;
            r_hi    <= '0;
            r_empty <= 1'b1;
        end else if (i_load) begin
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_empty <= 1'b0;
        end
    end

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

[rtl/core/transformed_point_bounding_box_core.sv]
// ----------------------------------------------------------------------------
// transformed_point_bounding_box_core: affine-transformed point bounding box
// Transforms each point by a configured 3x4 fixed-point matrix and reports
// the running axis-aligned box after every point.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                   payload
//  point     in         i_in_valid / o_in_ready     i_point_x/y/z, i_restart
//  box       out        o_out_valid / i_out_ready   o_min_x/y/z, o_max_x/y/z
//  config    in         i_cfg_we (no wait)          i_cfg_idx, i_cfg_data
//
//  One point per cycle sustained while results are taken; a result is
//  offered once its point has passed the four register stages: input,
//  products, rounded coordinates, box.
//  Each stage advances when it is empty or its successor advances, so
//  bubbles close up; behind a waiting result the input keeps taking points
//  until all four stages are full, then stalls until the result transfers.
//  Synchronous active-low reset clears all valid flags, empties the box and
//  loads the identity transform.
// ----------------------------------------------------------------------------
module transformed_point_bounding_box_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration
    input  logic             i_cfg_we,
    input  tpbb_pkg::t_cfg_idx i_cfg_idx,
    input  tpbb_pkg::t_row   i_cfg_data,
    // point input
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tpbb_pkg::t_coord i_point_x,
    input  tpbb_pkg::t_coord i_point_y,
    input  tpbb_pkg::t_coord i_point_z,
    input  logic             i_restart,
    // box output
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output tpbb_pkg::t_coord o_min_x,
    output tpbb_pkg::t_coord o_min_y,
    output tpbb_pkg::t_coord o_min_z,
    output tpbb_pkg::t_coord o_max_x,
    output tpbb_pkg::t_coord o_max_y,
    output tpbb_pkg::t_coord o_max_z
);

    tpbb_pkg::t_row      r_row [3];

    // stage valid flags
    logic                r_v_in;
    logic                r_v_mul;
    logic                r_v_sum;
    logic                r_out_valid;

    // payload carried along the stages
    tpbb_pkg::t_vec      r_pt;
    logic                r_rs_in;
    logic                r_rs_mul;
    logic                r_rs_sum;

    logic                in_xfer;
    logic                ld_out;
    tpbb_pkg::t_pipe_ctl ctl;
    tpbb_pkg::t_vec      xf_pt;
    tpbb_pkg::t_vec      box_lo;
    tpbb_pkg::t_vec      box_hi;

    // Configuration writes; an index beyond the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0] <= tpbb_pkg::ROW_X_RST;
            r_row[1] <= tpbb_pkg::ROW_Y_RST;
            r_row[2] <= tpbb_pkg::ROW_Z_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tpbb_pkg::CFG_ROW_X: r_row[0] <= i_cfg_data;
                tpbb_pkg::CFG_ROW_Y: r_row[1] <= i_cfg_data;
                tpbb_pkg::CFG_ROW_Z: r_row[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance chain: a stage loads when its source holds a point and it is
    // empty or is itself being emptied this cycle
    assign ld_out     = r_v_sum && (!r_out_valid || i_out_ready);
    assign ctl.ld_sum = r_v_mul && (!r_v_sum || ld_out);
    assign ctl.ld_mul = r_v_in  && (!r_v_mul || ctl.ld_sum);
    assign o_in_ready = !r_v_in || ctl.ld_mul;
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in      <= 1'b0;
            r_v_mul     <= 1'b0;
            r_v_sum     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_v_in <= 1'b1;
            end else if (ctl.ld_mul) begin
                r_v_in <= 1'b0;
            end
            if (ctl.ld_mul) begin
                r_v_mul <= 1'b1;
            end else if (ctl.ld_sum) begin
                r_v_mul <= 1'b0;
            end
            if (ctl.ld_sum) begin
                r_v_sum <= 1'b1;
            end else if (ld_out) begin
                r_v_sum <= 1'b0;
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the point and carry the restart flag alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_pt    <= {i_point_z, i_point_y, i_point_x};
            r_rs_in <= i_restart;
        end
        if (ctl.ld_mul) begin
            r_rs_mul <= r_rs_in;
        end
        if (ctl.ld_sum) begin
            r_rs_sum <= r_rs_mul;
        end
    end

    // One transform row per output axis
    for (genvar g = 0; g < 3; g++) begin : g_row
        tpbb_row u_row (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_row   (r_row[g]),
            .i_pt    (r_pt),
            .o_coord (xf_pt[g])
        );
    end

    // The box registers double as the result register
    tpbb_box u_box (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (ld_out),
        .i_restart (r_rs_sum),
        .i_pt      (xf_pt),
        .o_lo      (box_lo),
        .o_hi      (box_hi)
    );

    assign o_out_valid = r_out_valid;
    assign o_min_x     = box_lo[0];
    assign o_min_y     = box_lo[1];
    assign o_min_z     = box_lo[2];
    assign o_max_x     = box_hi[0];
    assign o_max_y     = box_hi[1];
    assign o_max_z     = box_hi[2];

endmodule

[rtl/core/tpbb_checker.sv]
// ----------------------------------------------------------------------------
// tpbb_checker: port-level checks for the bounding box core
// Output handshake rules, reset behaviour and the box ordering invariant.
// ----------------------------------------------------------------------------
module tpbb_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input tpbb_pkg::t_coord o_min_x,
    input tpbb_pkg::t_coord o_min_y,
    input tpbb_pkg::t_coord o_min_z,
    input tpbb_pkg::t_coord o_max_x,
    input tpbb_pkg::t_coord o_max_y,
    input tpbb_pkg::t_coord o_max_z
);

    // A stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its box
    a_box_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_min_x) && $stable(o_min_y)
            && $stable(o_min_z) && $stable(o_max_x) && $stable(o_max_y)
            && $stable(o_max_z))
        else $error("stalled box changed");

    // Every offered box is ordered on all three axes
    a_box_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_min_x) <= $signed(o_max_x))
            && ($signed(o_min_y) <= $signed(o_max_y))
            && ($signed(o_min_z) <= $signed(o_max_z)))
        else $error("box low corner above high corner");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind transformed_point_bounding_box_core tpbb_checker u_tpbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_min_x     (o_min_x),
    .o_min_y     (o_min_y),
    .o_min_z     (o_min_z),
    .o_max_x     (o_max_x),
    .o_max_y     (o_max_y),
    .o_max_z     (o_max_z)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for transformed_point_bounding_box_core
// Streams points through the affine transform and running box, predicts each
// box from its own fixed-point transform and box state, and compares every
// box transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

    // Long enough for the slowest legal run several times over
    localparam int CYCLE_LIMIT = 200000;
    // Receiver hold-off used to fill the pipeline and stall the input
    localparam int LONG_STALL  = 120;
    // Register index past the list; the block ignores a write to it
    localparam tpbb_pkg::t_cfg_idx CFG_UNUSED = 2'd3;

    typedef struct packed {
        tpbb_pkg::t_coord x;
        tpbb_pkg::t_coord y;
        tpbb_pkg::t_coord z;
        logic             restart;
    } t_point_item;

    typedef struct packed {
        tpbb_pkg::t_coord lo_x;
        tpbb_pkg::t_coord lo_y;
        tpbb_pkg::t_coord lo_z;
        tpbb_pkg::t_coord hi_x;
        tpbb_pkg::t_coord hi_y;
        tpbb_pkg::t_coord hi_z;
    } t_box_result;

    // ------------------------------------------------------------------------
    // Block inputs, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_cfg_we   = 1'b0;
    tpbb_pkg::t_cfg_idx i_cfg_idx  = tpbb_pkg::CFG_ROW_X;
    tpbb_pkg::t_row     i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    tpbb_pkg::t_coord   i_point_x  = '0;
    tpbb_pkg::t_coord   i_point_y  = '0;
    tpbb_pkg::t_coord   i_point_z  = '0;
    logic               i_restart  = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    tpbb_pkg::t_coord   o_min_x, o_min_y, o_min_z;
    tpbb_pkg::t_coord   o_max_x, o_max_y, o_max_z;

    transformed_point_bounding_box_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .i_point_z   (i_point_z),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_min_x     (o_min_x),
        .o_min_y     (o_min_y),
        .o_min_z     (o_min_z),
        .o_max_x     (o_max_x),
        .o_max_y     (o_max_y),
        .o_max_z     (o_max_z)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_point_item point_queue [$];   // points waiting to be offered
    t_box_result box_expect  [$];   // predicted boxes, oldest first

    int  points_pushed   = 0;
    int  points_accepted = 0;
    int  error_count     = 0;
    int  cycle_count     = 0;
    bit  point_taken     = 1'b0;    // the point on the bus transferred at the last edge

    int  sender_idle_pct   = 28;
    int  receiver_idle_pct = 58;
    int  stall_requests    = 0;     // bumped by the stimulus to ask for a hold-off
    int  stall_granted     = 0;
    int  stall_left        = 0;

    // Predictor copy of the transform rows and of the box
    tpbb_pkg::t_row   xform_row [3];
    tpbb_pkg::t_coord box_lo    [3] = '{16'sd0, 16'sd0, 16'sd0};
    tpbb_pkg::t_coord box_hi    [3] = '{16'sd0, 16'sd0, 16'sd0};
    bit               box_empty     = 1'b1;

    // ------------------------------------------------------------------------
    // Clock: period 8
    // ------------------------------------------------------------------------
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: transform one point, round half up, saturate, grow the box
    // ------------------------------------------------------------------------
    function automatic t_box_result grow_box(input t_point_item pt);
        tpbb_pkg::t_coord pin  [3];
        tpbb_pkg::t_coord pout [3];
        longint           acc;
        t_box_result      res;
        pin[0] = pt.x;
        pin[1] = pt.y;
        pin[2] = pt.z;
        for (int a = 0; a < 3; a++) begin
            // translation is an integer, so scale it up to Q.14 before summing
            acc = longint'($signed(xform_row[a][63:48])) * 64'sd16384;
            for (int k = 0; k < 3; k++) begin
                acc += longint'($signed(xform_row[a][16*k +: 16])) * longint'(pin[k]);
            end
            // floor((acc + half) / 2^14): ties go towards plus infinity
            acc = (acc + 64'sd8192) >>> 14;
            if (acc > 64'sd32767) begin
                pout[a] = 16'sh7FFF;
            end else if (acc < -64'sd32768) begin
                pout[a] = 16'sh8000;
            end else begin
                pout[a] = acc[15:0];
            end
        end
        for (int a = 0; a < 3; a++) begin
            if (pt.restart || box_empty) begin
                box_lo[a] = pout[a];
                box_hi[a] = pout[a];
            end else if (pout[a] < box_lo[a]) begin
                box_lo[a] = pout[a];
            end else if (pout[a] > box_hi[a]) begin
                box_hi[a] = pout[a];
            end
        end
        box_empty = 1'b0;
        res.lo_x = box_lo[0];
        res.lo_y = box_lo[1];
        res.lo_z = box_lo[2];
        res.hi_x = box_hi[0];
        res.hi_y = box_hi[1];
        res.hi_z = box_hi[2];
        return res;
    endfunction

    task automatic check_field(input string name, input tpbb_pkg::t_coord want,
                               input tpbb_pkg::t_coord got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Point driver: change at the falling edge, hold the payload until the
    // transfer, then either offer the next point or idle
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_point_item nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || point_taken) begin
            if (point_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                nxt = point_queue.pop_front();
                i_in_valid <= 1'b1;
                i_point_x  <= nxt.x;
                i_point_y  <= nxt.y;
                i_point_z  <= nxt.z;
                i_restart  <= nxt.restart;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Box receiver: random back-pressure, plus a long hold-off on request
    // that this process counts down itself
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_requests != stall_granted) begin
            stall_granted++;
            stall_left = LONG_STALL;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels at the rising edge; check box transfers
    // against the oldest prediction, predict for each point transfer
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_box_result want;
        t_point_item cur;
        point_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (box_expect.size() == 0) begin
                    $error("box transfer with no prediction waiting");
                    error_count++;
                end else begin
                    want = box_expect.pop_front();
                    check_field("min_x", want.lo_x, o_min_x);
                    check_field("min_y", want.lo_y, o_min_y);
                    check_field("min_z", want.lo_z, o_min_z);
                    check_field("max_x", want.hi_x, o_max_x);
                    check_field("max_y", want.hi_y, o_max_y);
                    check_field("max_z", want.hi_z, o_max_z);
                end
            end
            if (i_in_valid && o_in_ready) begin
                point_taken = 1'b1;
                points_accepted++;
                cur.x       = i_point_x;
                cur.y       = i_point_y;
                cur.z       = i_point_z;
                cur.restart = i_restart;
                box_expect.push_back(grow_box(cur));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_point(input int x, input int y, input int z, input bit restart);
        t_point_item pt;
        pt.x       = x[15:0];
        pt.y       = y[15:0];
        pt.z       = z[15:0];
        pt.restart = restart;
        point_queue.push_back(pt);
        points_pushed++;
    endtask

    // Hold until every queued point has transferred and every box has come back
    task automatic wait_drained();
        while (points_accepted != points_pushed || box_expect.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write the three rows on consecutive cycles, optionally poke the unused
    // index too, then drop the write enable; the block is idle throughout
    task automatic program_rows(input tpbb_pkg::t_row rx, input tpbb_pkg::t_row ry,
                                input tpbb_pkg::t_row rz, input bit poke_unused);
        tpbb_pkg::t_row vals [3];
        vals[0] = rx;
        vals[1] = ry;
        vals[2] = rz;
        for (int i = 0; i < 3; i++) begin
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= (i == 0) ? tpbb_pkg::CFG_ROW_X :
                          (i == 1) ? tpbb_pkg::CFG_ROW_Y : tpbb_pkg::CFG_ROW_Z;
            i_cfg_data <= vals[i];
            xform_row[i] = vals[i];
        end
        if (poke_unused) begin
            @(negedge i_clk);
            i_cfg_idx  <= CFG_UNUSED;
            i_cfg_data <= {$urandom(), $urandom()};
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Half small values and extremes, the other half anywhere in range
    function automatic int rand_coord();
        int pick [5] = '{-32768, 32767, 0, -1, 1};
        case ($urandom_range(0, 5))
            0:       return pick[$urandom_range(0, 4)];
            1, 2:    return int'($urandom_range(0, 255)) - 128;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    function automatic tpbb_pkg::t_row rand_row(input int axis);
        tpbb_pkg::t_row r;
        logic [15:0]    pick [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000};
        r = '0;
        case ($urandom_range(0, 4))
            0: r = {$urandom(), $urandom()};
            1: r = $urandom_range(0, 1) ? '0 : '1;
            2: begin
                for (int k = 0; k < 4; k++) begin
                    r[16*k +: 16] = pick[$urandom_range(0, 4)];
                end
            end
            default: begin
                // near identity: small cross terms and translation
                for (int k = 0; k < 4; k++) begin
                    r[16*k +: 16] = 16'($urandom_range(0, 1023) - 512);
                end
                r[16*axis +: 16] = 16'h4000 + 16'($urandom_range(0, 511)) - 16'd256;
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Run sequence
    // ------------------------------------------------------------------------
    initial begin
        xform_row[0] = tpbb_pkg::ROW_X_RST;
        xform_row[1] = tpbb_pkg::ROW_Y_RST;
        xform_row[2] = tpbb_pkg::ROW_Z_RST;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Identity transform from reset: first point into the empty box,
        // each axis lowering, raising and staying put, the coordinate
        // extremes, then a restart
        queue_point(5, -7, 100, 1'b0);
        queue_point(3, -9, 200, 1'b0);
        queue_point(10, 0, 150, 1'b0);
        queue_point(4, -8, 150, 1'b0);
        queue_point(-32768, -32768, -32768, 1'b0);
        queue_point(32767, 32767, 32767, 1'b0);
        queue_point(0, 0, 0, 1'b1);
        queue_point(-1, -1, -1, 1'b0);
        wait_drained();

        // Extreme coefficients and translations: drive the x and y rows into
        // saturation on both sides and pin z at the most negative coordinate
        program_rows(64'h7FFF_8000_8000_8000, 64'h8000_7FFF_7FFF_7FFF,
                     64'h8000_0000_0000_0000, 1'b0);
        queue_point(32767, 32767, 32767, 1'b1);
        queue_point(-32768, -32768, -32768, 1'b0);
        queue_point(0, 0, 0, 0);
        queue_point(-32768, 32767, 0, 1'b0);
        wait_drained();

        // Half-unit coefficients: exact ties round towards plus infinity;
        // the write to the unused index must leave the rows alone
        program_rows(64'h0000_0000_0000_2000, 64'h0000_0000_E000_0000,
                     64'hFFFF_2000_0000_0000, 1'b1);
        queue_point(1, 1, 1, 1'b1);
        queue_point(-1, -1, -1, 1'b0);
        queue_point(3, -3, -3, 1'b0);
        queue_point(-3, 3, 3, 1'b0);
        wait_drained();

        // Random part: three idling patterns, each with fresh rows per batch
        for (int mode = 0; mode < 3; mode++) begin
            sender_idle_pct   = (mode == 0) ? 28 : (mode == 1) ? 58 : 0;
            receiver_idle_pct = (mode == 0) ? 58 : (mode == 1) ? 28 : 0;
            for (int b = 0; b < 4; b++) begin
                program_rows(rand_row(0), rand_row(1), rand_row(2),
                             $urandom_range(0, 7) == 0);
                for (int n = 0; n < 50; n++) begin
                    queue_point(rand_coord(), rand_coord(), rand_coord(),
                                n == 0 || $urandom_range(0, 11) == 0);
                end
                // hold off the receiver in the first batch of the first two patterns so the pipeline backs up
                if (b == 0 && mode != 2) begin
                    stall_requests++;
                end
                wait_drained();
            end
        end

        // Let any stray result surface before the verdict
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/tpbb_pkg.sv
rtl/core/tpbb_row.sv
rtl/core/tpbb_box.sv
rtl/core/transformed_point_bounding_box_core.sv
rtl/core/tpbb_checker.sv
bench/tb.sv
